@@ sv/zpbc_pkg.sv @@
`timescale 1ns / 1ps
// zpbc_pkg: shared types, codes and coefficient table of the zero-phase biquad cascade
// no dependencies; used by zpbc_mul and zero_phase_biquad_cascade

package zpbc_pkg;

   // fixed formats
   localparam int STORE_BITS    = 24;
   localparam int STATE_BITS    = 48;
   localparam int COEF_BITS     = 32;
   localparam int MAG_BITS      = 49;
   localparam int ACC_BITS      = 52;
   localparam int SECTION_COUNT = 2;

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 7;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAD_MODE   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAD_LENGTH = 1'd1;

   // pad modes, anything else repeats the end sample
   localparam logic [1:0] PAD_ODD  = 2'd0;
   localparam logic [1:0] PAD_EVEN = 2'd1;

   // word actions
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // result status
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_SHORT = 2'd1;
   localparam logic [1:0] STAT_NONE  = 2'd2;

   // coefficient slots of one section
   localparam logic [2:0] K_B0 = 3'd0;
   localparam logic [2:0] K_B1 = 3'd1;
   localparam logic [2:0] K_B2 = 3'd2;
   localparam logic [2:0] K_A1 = 3'd3;
   localparam logic [2:0] K_A2 = 3'd4;

   // b0, b1, b2, a1, a2 per section in Q2.30
   localparam logic signed [COEF_BITS-1:0] COEF_Q30 [SECTION_COUNT][5] = '{
      '{32'sd652380224, 32'sd1304760438, 32'sd652380224, 32'sd1145063911, 32'sd408917963},
      '{32'sd1073741824, 32'sh80000000, 32'sd1073741824, -32'sd2132575870,
        32'sd1058937179}
   };

   typedef struct packed {
      logic                         start;
      logic signed [STATE_BITS-1:0] w;
      logic signed [COEF_BITS-1:0]  c;
   } mul_req_type;

   typedef struct packed {
      logic                done;
      logic                neg;
      logic [MAG_BITS-1:0] mag;
   } mul_rsp_type;

   // coefficient rescaled to frac fractional bits, rounded half up
   function automatic logic signed [COEF_BITS-1:0] coef_value(input logic sec,
                                                              input logic [2:0] k,
                                                              input int frac);
      logic signed [COEF_BITS:0] c;
      int                        s;
      c = (COEF_BITS+1)'(COEF_Q30[sec][k]);
      s = 30 - frac;
      if (s > 0) begin
         c = (c + ((COEF_BITS+1)'(1) <<< (s - 1))) >>> s;
      end
      return c[COEF_BITS-1:0];
   endfunction

endpackage

@@ sv/zpbc_ifs.sv @@
`timescale 1ns / 1ps
// zpbc_req_if and zpbc_rsp_if: valid/ready channels of the zero-phase biquad cascade
// no dependencies

interface zpbc_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last;
   modport source (output valid, action, sample, last, input ready);
   modport sink (input valid, action, sample, last, output ready);
endinterface

interface zpbc_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] filtered_sample;
   logic                          final_res;
   logic [1:0]                    status;
   modport source (output valid, filtered_sample, final_res, status, input ready);
   modport sink (input valid, filtered_sample, final_res, status, output ready);
endinterface

@@ sv/zpbc_mul.sv @@
`timescale 1ns / 1ps
// zpbc_mul: shared rounding fixed-point multiplier, 48-bit state times 32-bit coefficient
// uses zpbc_pkg; one 24x32 multiplier, two partial products per request

module zpbc_mul #(
   parameter int COEF_FRAC = 30
) (
   input  logic                  clock,
   input  logic                  reset,
   input  zpbc_pkg::mul_req_type mul_req,
   output zpbc_pkg::mul_rsp_type mul_rsp
);

   localparam int HW = zpbc_pkg::STATE_BITS / 2;
   localparam int PB = HW + zpbc_pkg::COEF_BITS;
   localparam int FB = zpbc_pkg::STATE_BITS + zpbc_pkg::COEF_BITS;

   logic [zpbc_pkg::STATE_BITS-1:0] mw_ff, mw_in;
   logic [zpbc_pkg::COEF_BITS-1:0]  mc_ff, mc_in;
   logic                            neg_ff, neg_in;
   logic [2:0]                      stage_ff, stage_in;
   logic [PB-1:0]                   lo_ff, hi_ff;
   logic [zpbc_pkg::MAG_BITS-1:0]   mag_ff;
   logic                            done_ff;
   logic [HW-1:0]                   opa;
   logic [PB-1:0]                   prod;
   logic [FB-1:0]                   full;

   // operand magnitudes and result sign on a new request
   always_comb begin
      mw_in    = mw_ff;
      mc_in    = mc_ff;
      neg_in   = neg_ff;
      stage_in = {stage_ff[1:0], 1'b0};
      if (mul_req.start) begin
         mw_in    = mul_req.w[zpbc_pkg::STATE_BITS-1] ? -mul_req.w : mul_req.w;
         mc_in    = mul_req.c[zpbc_pkg::COEF_BITS-1] ? -mul_req.c : mul_req.c;
         neg_in   = mul_req.w[zpbc_pkg::STATE_BITS-1] ^ mul_req.c[zpbc_pkg::COEF_BITS-1];
         stage_in = 3'b001;
      end
   end

   // the shared multiplier: low half first, then high half
   assign opa  = stage_ff[1] ? mw_ff[zpbc_pkg::STATE_BITS-1:HW] : mw_ff[HW-1:0];
   assign prod = PB'(opa) * PB'(mc_ff);

   // recombine and round half away from zero on the magnitude
   assign full = FB'(lo_ff) + (FB'(hi_ff) << HW) + (FB'(1) << (COEF_FRAC - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= stage_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      mw_ff  <= mw_in;
      mc_ff  <= mc_in;
      neg_ff <= neg_in;
      if (stage_ff[0]) begin
         lo_ff <= prod;
      end
      if (stage_ff[1]) begin
         hi_ff <= prod;
      end
      if (stage_ff[2]) begin
         mag_ff <= full[COEF_FRAC +: zpbc_pkg::MAG_BITS];
      end
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.neg  = neg_ff;
   assign mul_rsp.mag  = mag_ff;

endmodule

@@ sv/zpbc_store.sv @@
`timescale 1ns / 1ps
// zpbc_store: signal store, one write and one registered read per cycle
// no dependencies

module zpbc_store #(
   parameter int DEPTH = 1152,
   parameter int AW    = 11,
   parameter int DW    = 24
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/zero_phase_biquad_cascade.sv @@
`timescale 1ns / 1ps
// Zero-phase two-section biquad filter. Load words (action 0) write the sample into the
// signal store and leave the block ready for the next word; the load with last set starts
// filtering unless the signal is too short for its padding, and the block then takes no
// word until filtering is done: it first builds the end extensions (p samples per side)
// from the two end samples, then four passes of direct form II biquads visit each padded
// sample with a store read and five coefficient products on the shared multiplier (each
// from two 24x32 partial products). A read word (action 1) reads the store, waits while an
// earlier result is not yet taken and lands in the output register; status 1 reports a
// signal too short for its padding, status 2 a read with nothing pending.
// Depends on zpbc_pkg, zpbc_ifs, zpbc_mul, zpbc_store.

module zero_phase_biquad_cascade #(
   parameter int MAX_LEN     = 1024,
   parameter int MAX_PAD     = 64,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_FRAC   = 30
) (
   input logic                                 clock,
   input logic                                 reset,
   zpbc_req_if.sink                            req_if,
   zpbc_rsp_if.source                          rsp_if,
   input logic                                 csr_we,
   input logic [zpbc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input logic [zpbc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int DEPTH      = MAX_LEN + 2 * MAX_PAD;
   localparam int AW         = $clog2(DEPTH);
   localparam int LW         = $clog2(DEPTH + 1);
   localparam int CW         = $clog2(MAX_LEN + 1);
   localparam int PW         = (MAX_PAD > 0) ? $clog2(MAX_PAD + 1) : 1;
   localparam int STORE_FRAC = (SAMPLE_BITS <= 22) ? 22 - SAMPLE_BITS : 0;
   localparam int HALF       = (STORE_FRAC > 0) ? (1 << (STORE_FRAC - 1)) : 0;
   localparam int SB         = zpbc_pkg::STORE_BITS;
   localparam int AB         = zpbc_pkg::ACC_BITS;
   localparam int XB         = zpbc_pkg::STATE_BITS;

   // product order within one biquad step
   localparam logic [2:0] OP_A1 = 3'd0;
   localparam logic [2:0] OP_A2 = 3'd1;
   localparam logic [2:0] OP_B0 = 3'd2;
   localparam logic [2:0] OP_B1 = 3'd3;
   localparam logic [2:0] OP_B2 = 3'd4;

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b00000000001,
      ST_RD_WAIT = 11'b00000000010,
      ST_P_RD0   = 11'b00000000100,
      ST_P_RD1   = 11'b00000001000,
      ST_P_RDF   = 11'b00000010000,
      ST_P_WRF   = 11'b00000100000,
      ST_P_WRB   = 11'b00001000000,
      ST_F_RD    = 11'b00010000000,
      ST_F_X     = 11'b00100000000,
      ST_M_ISSUE = 11'b01000000000,
      ST_M_WAIT  = 11'b10000000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 rpos_ff, rpos_in;
   logic                          ready_res_ff, ready_res_in;
   logic                          short_ff, short_in;
   logic [1:0]                    mode_ff, mode_in;
   logic [6:0]                    padlen_ff, padlen_in;
   logic [PW-1:0]                 p_ff, p_in;
   logic [LW-1:0]                 i_ff, i_in;
   logic [1:0]                    pass_ff, pass_in;
   logic [2:0]                    op_ff, op_in;
   logic signed [AB-1:0]          acc_ff, acc_in;
   logic signed [XB-1:0]          d1_ff, d1_in;
   logic signed [XB-1:0]          d2_ff, d2_in;
   logic signed [XB-1:0]          wn_ff, wn_in;
   logic signed [SB-1:0]          x0_ff, x0_in;
   logic signed [SB-1:0]          xe_ff, xe_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_final_ff, rsp_final_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;

   logic                          mem_we;
   logic [AW-1:0]                 mem_waddr;
   logic signed [SB-1:0]          mem_wdata;
   logic                          mem_re;
   logic [AW-1:0]                 mem_raddr;
   logic signed [SB-1:0]          mem_rdata;

   zpbc_pkg::mul_req_type         mul_req;
   zpbc_pkg::mul_rsp_type         mul_rsp;
   logic signed [XB-1:0]          mul_w;
   logic [2:0]                    mul_k;
   logic signed [AB-1:0]          acc_next;
   logic                          acc_sub;
   logic [PW-1:0]                 p_eff;
   logic [CW-1:0]                 cnt_base;
   logic [CW-1:0]                 cnt_new;
   logic signed [SB-1:0]          load_value;
   logic signed [SB+1:0]          pad_calc;
   int                            n32, p32, i32;
   int                            filt_idx;
   logic                          pass_last_i;

   function automatic logic signed [XB-1:0] sat_state(input logic signed [AB-1:0] v);
      if ((&v[AB-1:XB-1]) || !(|v[AB-1:XB-1])) begin
         return v[XB-1:0];
      end
      return {v[AB-1], {(XB-1){~v[AB-1]}}};
   endfunction

   function automatic logic signed [SB-1:0] sat_store(input logic signed [AB-1:0] v);
      if ((&v[AB-1:SB-1]) || !(|v[AB-1:SB-1])) begin
         return v[SB-1:0];
      end
      return {v[AB-1], {(SB-1){~v[AB-1]}}};
   endfunction

   function automatic logic signed [SB-1:0] sat_pad(input logic signed [SB+1:0] v);
      if ((&v[SB+1:SB-1]) || !(|v[SB+1:SB-1])) begin
         return v[SB-1:0];
      end
      return {v[SB+1], {(SB-1){~v[SB+1]}}};
   endfunction

   // round half up to an integer sample and saturate
   function automatic logic signed [SAMPLE_BITS-1:0] round_out(input logic signed [SB-1:0] v);
      logic signed [SB:0] s;
      s = (SB + 1)'(v);
      s = (s + (SB + 1)'(HALF)) >>> STORE_FRAC;
      if ((&s[SB:SAMPLE_BITS-1]) || !(|s[SB:SAMPLE_BITS-1])) begin
         return s[SAMPLE_BITS-1:0];
      end
      return {s[SB], {(SAMPLE_BITS-1){~s[SB]}}};
   endfunction

   zpbc_mul #(
      .COEF_FRAC (COEF_FRAC)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   zpbc_store #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (SB)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // handshake and payload
   assign req_if.ready           = (state_ff == ST_IDLE);
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.filtered_sample = rsp_data_ff;
   assign rsp_if.final_res       = rsp_final_ff;
   assign rsp_if.status          = rsp_status_ff;

   // common index arithmetic
   assign n32         = int'(count_ff);
   assign p32         = int'(p_ff);
   assign i32         = int'(i_ff);
   assign filt_idx    = pass_ff[1] ? (MAX_PAD + n32 + p32 - 1 - i32) : (MAX_PAD - p32 + i32);
   assign pass_last_i = (i32 == n32 + 2 * p32 - 1);
   assign p_eff       = (int'(padlen_ff) > MAX_PAD) ? PW'(MAX_PAD) : PW'(padlen_ff);
   assign cnt_base    = (ready_res_ff || short_ff) ? '0 : count_ff;
   assign cnt_new     = (int'(cnt_base) < MAX_LEN) ? CW'(int'(cnt_base) + 1) : cnt_base;
   assign load_value  = SB'(req_if.sample) <<< STORE_FRAC;

   // operand and coefficient for the current product
   always_comb begin
      case (op_ff)
         OP_A1: begin
            mul_w = d1_ff;
            mul_k = zpbc_pkg::K_A1;
         end
         OP_A2: begin
            mul_w = d2_ff;
            mul_k = zpbc_pkg::K_A2;
         end
         OP_B0: begin
            mul_w = wn_ff;
            mul_k = zpbc_pkg::K_B0;
         end
         OP_B1: begin
            mul_w = d1_ff;
            mul_k = zpbc_pkg::K_B1;
         end
         default: begin
            mul_w = d2_ff;
            mul_k = zpbc_pkg::K_B2;
         end
      endcase
   end

   assign mul_req.start = (state_ff == ST_M_ISSUE);
   assign mul_req.w     = mul_w;
   assign mul_req.c     = zpbc_pkg::coef_value(pass_ff[0], mul_k, COEF_FRAC);

   // feedback products subtract, feedforward products add
   assign acc_sub  = ((op_ff == OP_A1) || (op_ff == OP_A2)) ^ mul_rsp.neg;
   assign acc_next = acc_sub ? (acc_ff - AB'(mul_rsp.mag)) : (acc_ff + AB'(mul_rsp.mag));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rpos_in       = rpos_ff;
      ready_res_in  = ready_res_ff;
      short_in      = short_ff;
      mode_in       = mode_ff;
      padlen_in     = padlen_ff;
      p_in          = p_ff;
      i_in          = i_ff;
      pass_in       = pass_ff;
      op_in         = op_ff;
      acc_in        = acc_ff;
      d1_in         = d1_ff;
      d2_in         = d2_ff;
      wn_in         = wn_ff;
      x0_in         = x0_ff;
      xe_in         = xe_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_final_in  = rsp_final_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      pad_calc      = '0;

      // register writes
      if (csr_we) begin
         if (csr_index == zpbc_pkg::CSR_PAD_MODE) begin
            mode_in = csr_wdata[1:0];
         end
         if (csr_index == zpbc_pkg::CSR_PAD_LENGTH) begin
            padlen_in = csr_wdata;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               if (req_if.action == zpbc_pkg::ACT_LOAD) begin
                  // a new load drops any pending results
                  if (ready_res_ff || short_ff) begin
                     ready_res_in = 1'b0;
                     short_in     = 1'b0;
                     rpos_in      = '0;
                  end
                  if (int'(cnt_base) < MAX_LEN) begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(MAX_PAD + int'(cnt_base));
                     mem_wdata = load_value;
                  end
                  count_in = cnt_new;
                  if (req_if.last) begin
                     rpos_in = '0;
                     if (int'(cnt_new) <= int'(p_eff)) begin
                        short_in = 1'b1;
                     end else begin
                        p_in = p_eff;
                        i_in = '0;
                        if (p_eff == '0) begin
                           pass_in  = '0;
                           d1_in    = '0;
                           d2_in    = '0;
                           state_in = ST_F_RD;
                        end else begin
                           state_in = ST_P_RD0;
                        end
                     end
                  end
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = AW'(MAX_PAD + int'(rpos_ff));
                  state_in  = ST_RD_WAIT;
               end
            end
         end

         ST_RD_WAIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (short_ff) begin
                  rsp_data_in   = '0;
                  rsp_final_in  = 1'b1;
                  rsp_status_in = zpbc_pkg::STAT_SHORT;
                  short_in      = 1'b0;
                  count_in      = '0;
               end else if (!ready_res_ff || (int'(rpos_ff) >= n32)) begin
                  rsp_data_in   = '0;
                  rsp_final_in  = 1'b0;
                  rsp_status_in = zpbc_pkg::STAT_NONE;
               end else begin
                  rsp_data_in   = round_out(mem_rdata);
                  rsp_final_in  = (int'(rpos_ff) + 1 >= n32);
                  rsp_status_in = zpbc_pkg::STAT_OK;
                  rpos_in       = CW'(int'(rpos_ff) + 1);
                  if (int'(rpos_ff) + 1 >= n32) begin
                     ready_res_in = 1'b0;
                     count_in     = '0;
                     rpos_in      = '0;
                  end
               end
            end
         end

         // end samples for the extensions
         ST_P_RD0: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(MAX_PAD);
            state_in  = ST_P_RD1;
         end

         ST_P_RD1: begin
            x0_in     = mem_rdata;
            mem_re    = 1'b1;
            mem_raddr = AW'(MAX_PAD + n32 - 1);
            state_in  = ST_P_RDF;
         end

         ST_P_RDF: begin
            xe_in     = mem_rdata;
            mem_re    = 1'b1;
            mem_raddr = AW'(MAX_PAD + p32 - i32);
            state_in  = ST_P_WRF;
         end

         // front extension sample, fetch the mirror source for the back one
         ST_P_WRF: begin
            if (mode_ff == zpbc_pkg::PAD_ODD) begin
               pad_calc = ((SB + 2)'(x0_ff) <<< 1) - (SB + 2)'(mem_rdata);
            end else if (mode_ff == zpbc_pkg::PAD_EVEN) begin
               pad_calc = (SB + 2)'(mem_rdata);
            end else begin
               pad_calc = (SB + 2)'(x0_ff);
            end
            mem_we    = 1'b1;
            mem_waddr = AW'(MAX_PAD - p32 + i32);
            mem_wdata = sat_pad(pad_calc);
            mem_re    = 1'b1;
            mem_raddr = AW'(MAX_PAD + n32 - 2 - i32);
            state_in  = ST_P_WRB;
         end

         // back extension sample
         ST_P_WRB: begin
            if (mode_ff == zpbc_pkg::PAD_ODD) begin
               pad_calc = ((SB + 2)'(xe_ff) <<< 1) - (SB + 2)'(mem_rdata);
            end else if (mode_ff == zpbc_pkg::PAD_EVEN) begin
               pad_calc = (SB + 2)'(mem_rdata);
            end else begin
               pad_calc = (SB + 2)'(xe_ff);
            end
            mem_we    = 1'b1;
            mem_waddr = AW'(MAX_PAD + n32 + i32);
            mem_wdata = sat_pad(pad_calc);
            if (i32 == p32 - 1) begin
               i_in     = '0;
               pass_in  = '0;
               d1_in    = '0;
               d2_in    = '0;
               state_in = ST_F_RD;
            end else begin
               i_in      = LW'(i32 + 1);
               mem_re    = 1'b1;
               mem_raddr = AW'(MAX_PAD + p32 - i32 - 1);
               state_in  = ST_P_WRF;
            end
         end

         ST_F_RD: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(filt_idx);
            state_in  = ST_F_X;
         end

         ST_F_X: begin
            acc_in   = AB'(mem_rdata);
            op_in    = OP_A1;
            state_in = ST_M_ISSUE;
         end

         ST_M_ISSUE: begin
            state_in = ST_M_WAIT;
         end

         ST_M_WAIT: begin
            if (mul_rsp.done) begin
               state_in = ST_M_ISSUE;
               case (op_ff)
                  OP_A1: begin
                     acc_in = acc_next;
                     op_in  = OP_A2;
                  end
                  OP_A2: begin
                     wn_in  = sat_state(acc_next);
                     acc_in = '0;
                     op_in  = OP_B0;
                  end
                  OP_B0: begin
                     acc_in = acc_next;
                     op_in  = OP_B1;
                  end
                  OP_B1: begin
                     acc_in = acc_next;
                     op_in  = OP_B2;
                  end
                  default: begin
                     // section output back into the store, shift the delay line
                     mem_we    = 1'b1;
                     mem_waddr = AW'(filt_idx);
                     mem_wdata = sat_store(acc_next);
                     d2_in     = d1_ff;
                     d1_in     = wn_ff;
                     state_in  = ST_F_RD;
                     if (pass_last_i) begin
                        i_in = '0;
                        if (pass_ff == 2'd3) begin
                           ready_res_in = 1'b1;
                           rpos_in      = '0;
                           state_in     = ST_IDLE;
                        end else begin
                           pass_in = pass_ff + 2'd1;
                           d1_in   = '0;
                           d2_in   = '0;
                        end
                     end else begin
                        i_in = LW'(i32 + 1);
                     end
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rpos_ff      <= '0;
         ready_res_ff <= 1'b0;
         short_ff     <= 1'b0;
         mode_ff      <= zpbc_pkg::PAD_ODD;
         padlen_ff    <= 7'd6;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= '0;
         op_ff        <= OP_A1;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rpos_ff      <= rpos_in;
         ready_res_ff <= ready_res_in;
         short_ff     <= short_in;
         mode_ff      <= mode_in;
         padlen_ff    <= padlen_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff      <= pass_in;
         op_ff        <= op_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      p_ff          <= p_in;
      i_ff          <= i_in;
      acc_ff        <= acc_in;
      d1_ff         <= d1_in;
      d2_ff         <= d2_in;
      wn_ff         <= wn_in;
      x0_ff         <= x0_in;
      xe_ff         <= xe_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_final_ff  <= rsp_final_in;
      rsp_status_ff <= rsp_status_in;
   end

   // checks
   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == ST_M_WAIT))
      else $error("multiplier result outside of wait state");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ready_res_ff && short_ff))
      else $error("results pending and too-short flag both set");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == ST_RD_WAIT))
      else $error("result word raised without a read");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (int'(count_ff) <= MAX_LEN) && (int'(rpos_ff) <= int'(count_ff)))
      else $error("sample count or read position out of range");

endmodule
